/* design/assert_macros.svh */
// assertion macros for the circular list engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CLE_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CLE_ASSERT_NEXT(name, clk, rst, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define CLE_ASSERT(name, clk, rst, prop, msg)
`define CLE_ASSERT_NEXT(name, clk, rst, cond, prop, msg)
`endif

`endif

/* design/cle_pkg.sv */
// types and constants of the circular list engine
`default_nettype none

package cle_pkg;

  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int ITEM_W = 32;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_AFTER = 3'd1,
    OP_INS_END   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP      = 3'd6,
    OP_RSVD      = 3'd7   // unused code, dropped without a result
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_INS_RD,
    S_INS_WR1,
    S_INS_WR2,
    S_DEL_RD1,
    S_DEL_RD2,
    S_DEL_WR,
    S_DUMP_FETCH,
    S_DUMP_OUT,
    S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    latch_in;
    logic    start;
    logic    walk_step;
    logic    prev_from_q;
    logic    ins_rd;
    logic    ins_wr1;
    logic    ins_wr2;
    logic    del_rd1;
    logic    del_rd2;
    logic    del_wr;
    logic    dump_fetch;
    logic    dump_out;
    logic    resp;
    status_t resp_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            pos_zero;
    logic            pos_gt_count;
    logic            count_one;
    logic            t_zero;
    logic            k_zero;
    logic            out_free;
  } sts_t;

endpackage

`default_nettype wire

/* design/cle_ifs.sv */
// request and response channel interfaces
`default_nettype none

interface cle_req_if import cle_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         position;
  logic signed [ITEM_W-1:0] value;
  modport source (output valid, op, position, value, input ready);
  modport sink (input valid, op, position, value, output ready);
endinterface

interface cle_rsp_if import cle_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ITEM_W-1:0] item;
  logic [STAT_W-1:0]        status;
  logic                     last;
  modport source (output valid, item, status, last, input ready);
  modport sink (input valid, item, status, last, output ready);
endinterface

`default_nettype wire

/* design/cle_datapath.sv */
// list stores, pointers, free-slot stack and output register
`default_nettype none

module cle_datapath import cle_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_t                     cmd,
  output sts_t                          sts,
  input  wire logic [OP_W-1:0]          in_op,
  input  wire logic [POS_W-1:0]         in_position,
  input  wire logic signed [ITEM_W-1:0] in_value,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic signed [ITEM_W-1:0]      out_item,
  output logic [STAT_W-1:0]             out_status,
  output logic                          out_last
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [ITEM_W-1:0] value_mem [CAPACITY];
  logic [SW-1:0]            link_mem  [CAPACITY];
  logic [SW-1:0]            free_mem  [CAPACITY];

  logic [OP_W-1:0]          op_q;
  logic [POS_W-1:0]         pos_q;
  logic signed [ITEM_W-1:0] val_in;
  logic [SW-1:0]            tail;
  logic [CW-1:0]            count;
  logic [CW-1:0]            stack_cnt;
  logic [CW-1:0]            fresh;
  logic [POS_W-1:0]         k;
  logic [SW-1:0]            prev;
  logic [SW-1:0]            slot;
  logic [SW-1:0]            victim;
  logic [SW-1:0]            link_q;
  logic [SW-1:0]            free_q;
  logic signed [ITEM_W-1:0] val_q;

  logic [POS_W-1:0] count_ext;
  logic [POS_W-1:0] t;
  logic [SW-1:0]    link_rd_addr;
  logic             link_rd_en;
  logic             link_wr_en;
  logic [SW-1:0]    link_wr_addr;
  logic [SW-1:0]    link_wr_data;
  logic             pop_stack;
  logic [SW-1:0]    new_slot;
  logic             push_en;
  logic [SW-1:0]    push_slot;
  logic             out_free;

  assign count_ext = POS_W'(count);

  // walk target: number of link steps from the tail
  always_comb begin
    case (op_q)
      OP_INS_AFTER: t = pos_q;
      OP_INS_END:   t = count_ext;
      OP_DUMP:      t = count_ext;
      OP_DEL_END:   t = count_ext - POS_W'(1);
      OP_DEL_AT:    t = pos_q - POS_W'(1);
      default:      t = '0;
    endcase
  end

  // slot allocation: recycled slots first, then never-used ones
  assign pop_stack = (stack_cnt != '0);
  assign new_slot  = pop_stack ? free_q : fresh[SW-1:0];
  assign push_en   = cmd.del_wr;
  assign push_slot = (count == CW'(1)) ? tail : victim;

  // link store read address
  always_comb begin
    link_rd_addr = link_q;
    if (cmd.start) begin
      link_rd_addr = tail;
    end else if (cmd.ins_rd || cmd.del_rd1) begin
      link_rd_addr = prev;
    end
  end
  assign link_rd_en = cmd.start || cmd.walk_step || cmd.ins_rd || cmd.del_rd1 ||
                      cmd.del_rd2 || cmd.dump_fetch;

  // link store write port
  always_comb begin
    link_wr_en   = 1'b0;
    link_wr_addr = prev;
    link_wr_data = link_q;
    if (cmd.ins_wr1) begin
      link_wr_en   = 1'b1;
      link_wr_addr = new_slot;
      link_wr_data = (count == '0) ? new_slot : link_q;
    end else if (cmd.ins_wr2) begin
      link_wr_en   = 1'b1;
      link_wr_data = slot;
    end else if (cmd.del_wr && count != CW'(1)) begin
      link_wr_en   = 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (link_wr_en) begin
      link_mem[link_wr_addr] <= link_wr_data;
    end
    if (link_rd_en) begin
      link_q <= link_mem[link_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_wr1) begin
      value_mem[new_slot] <= val_in;
    end
    if (cmd.dump_fetch) begin
      val_q <= value_mem[link_q];
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      free_mem[stack_cnt[SW-1:0]] <= push_slot;
    end
    if (cmd.ins_rd) begin
      free_q <= free_mem[SW'(stack_cnt - CW'(1))];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q   <= in_op;
      pos_q  <= in_position;
      val_in <= in_value;
    end
    if (cmd.start) begin
      prev <= tail;
    end else if (cmd.prev_from_q) begin
      prev <= link_q;
    end
    if (cmd.ins_wr1) begin
      slot <= new_slot;
    end
    if (cmd.del_rd2) begin
      victim <= link_q;
    end
  end

  // list control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tail      <= '0;
      count     <= '0;
      stack_cnt <= '0;
      fresh     <= '0;
      k         <= '0;
    end else begin
      if (cmd.start) begin
        k <= t - POS_W'(1);
      end else if (cmd.walk_step || cmd.dump_out) begin
        k <= k - POS_W'(1);
      end
      if (cmd.ins_wr1) begin
        if (pop_stack) begin
          stack_cnt <= stack_cnt - CW'(1);
        end else begin
          fresh <= fresh + CW'(1);
        end
      end
      if (cmd.ins_wr2) begin
        if (count == '0 || t == count_ext) begin
          tail <= slot;
        end
        count <= count + CW'(1);
      end
      if (cmd.del_wr) begin
        stack_cnt <= stack_cnt + CW'(1);
        if (count == CW'(1)) begin
          tail  <= '0;
          count <= '0;
        end else begin
          if (t + POS_W'(1) == count_ext) begin
            tail <= prev;
          end
          count <= count - CW'(1);
        end
      end
    end
  end

  // output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resp || cmd.dump_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_item   <= '0;
      out_status <= cmd.resp_status;
      out_last   <= 1'b1;
    end else if (cmd.dump_out) begin
      out_item   <= val_q;
      out_status <= ST_OK;
      out_last   <= (k == '0);
    end
  end

  // status toward the controller
  always_comb begin
    sts.op           = op_q;
    sts.empty        = (count == '0);
    sts.full         = (count >= CW'(CAPACITY));
    sts.pos_zero     = (pos_q == '0);
    sts.pos_gt_count = (pos_q > count_ext);
    sts.count_one    = (count == CW'(1));
    sts.t_zero       = (t == '0);
    sts.k_zero       = (k == '0);
    sts.out_free     = out_free;
  end

endmodule

`default_nettype wire

/* design/cle_ctrl.sv */
// operation sequencer of the circular list engine
`default_nettype none

module cle_ctrl import cle_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t  state;
  state_t  state_next;
  status_t stat;
  status_t chk_code;
  logic    chk_err;
  logic    is_ins;

  assign is_ins = (sts.op == OP_INS_FRONT) || (sts.op == OP_INS_AFTER) ||
                  (sts.op == OP_INS_END);

  // precondition checks in the order empty, position, full
  always_comb begin
    chk_err  = 1'b0;
    chk_code = ST_OK;
    case (sts.op)
      OP_INS_FRONT, OP_INS_END: begin
        if (sts.full) begin
          chk_err  = 1'b1;
          chk_code = ST_FULL;
        end
      end
      OP_INS_AFTER: begin
        if (sts.empty && !sts.pos_zero) begin
          chk_err  = 1'b1;
          chk_code = ST_EMPTY;
        end else if (sts.pos_gt_count) begin
          chk_err  = 1'b1;
          chk_code = ST_NOTFOUND;
        end else if (sts.full) begin
          chk_err  = 1'b1;
          chk_code = ST_FULL;
        end
      end
      OP_DEL_FRONT, OP_DEL_END, OP_DUMP: begin
        if (sts.empty) begin
          chk_err  = 1'b1;
          chk_code = ST_EMPTY;
        end
      end
      OP_DEL_AT: begin
        if (sts.empty) begin
          chk_err  = 1'b1;
          chk_code = ST_EMPTY;
        end else if (sts.pos_zero || sts.pos_gt_count) begin
          chk_err  = 1'b1;
          chk_code = ST_NOTFOUND;
        end
      end
      default: begin
        chk_err  = 1'b0;
        chk_code = ST_OK;
      end
    endcase
  end

  // state and status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stat  <= ST_OK;
    end else begin
      state <= state_next;
      if (state == S_DECODE) begin
        stat <= chk_code;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_INS_FRONT, OP_INS_AFTER, OP_INS_END: begin
            if (chk_err) begin
              state_next = S_RESP;
            end else begin
              state_next = sts.t_zero ? S_INS_RD : S_WALK;
            end
          end
          OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT: begin
            if (chk_err) begin
              state_next = S_RESP;
            end else if (sts.count_one) begin
              state_next = S_DEL_WR;
            end else begin
              state_next = sts.t_zero ? S_DEL_RD1 : S_WALK;
            end
          end
          OP_DUMP: begin
            state_next = chk_err ? S_RESP : S_DUMP_FETCH;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_WALK: begin
        if (sts.k_zero) begin
          state_next = is_ins ? S_INS_RD : S_DEL_RD1;
        end
      end
      S_INS_RD:     state_next = S_INS_WR1;
      S_INS_WR1:    state_next = S_INS_WR2;
      S_INS_WR2:    state_next = S_RESP;
      S_DEL_RD1:    state_next = S_DEL_RD2;
      S_DEL_RD2:    state_next = S_DEL_WR;
      S_DEL_WR:     state_next = S_RESP;
      S_DUMP_FETCH: state_next = S_DUMP_OUT;
      S_DUMP_OUT: begin
        if (sts.out_free) begin
          state_next = sts.k_zero ? S_IDLE : S_DUMP_FETCH;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd             = '0;
    cmd.resp_status = stat;
    in_ready        = (state == S_IDLE);
    case (state)
      S_IDLE:       cmd.latch_in = in_valid;
      S_DECODE:     cmd.start = 1'b1;
      S_WALK: begin
        cmd.walk_step   = !sts.k_zero;
        cmd.prev_from_q = sts.k_zero;
      end
      S_INS_RD:     cmd.ins_rd = 1'b1;
      S_INS_WR1:    cmd.ins_wr1 = 1'b1;
      S_INS_WR2:    cmd.ins_wr2 = 1'b1;
      S_DEL_RD1:    cmd.del_rd1 = 1'b1;
      S_DEL_RD2:    cmd.del_rd2 = 1'b1;
      S_DEL_WR:     cmd.del_wr = 1'b1;
      S_DUMP_FETCH: cmd.dump_fetch = 1'b1;
      S_DUMP_OUT:   cmd.dump_out = sts.out_free;
      S_RESP:       cmd.resp = sts.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/circular_list_engine_unit.sv */
// Circular singly linked list engine: holds up to CAPACITY signed 32-bit values in a
// value store and a link store, with a tail pointer, an element count and a slot
// allocator (a stack of recycled slots backed by a counter of never-used slots, so no
// clearing pass is needed after reset). One request is worked at a time; a request is
// taken only while the sequencer is idle, and results leave through an output register.
// Insert and delete walk to the neighbor element before writing, doing one link-store read per
// cycle, so the cost grows with the position (end delete and end-position insert walk the
// whole list); a failed check skips the walk and goes straight to the status result. A dump
// reads each element's link and then its value through the registered store reads before
// loading it into the output register. The sequencer returns to idle as the last result is
// loaded, which waits while the output register is held by the receiver. Op code 7 is
// dropped without a result.
`default_nettype none

module circular_list_engine_unit import cle_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input wire logic clk,
  input wire logic rst,
  cle_req_if.sink  req,
  cle_rsp_if.source rsp
);

  `include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;
  logic out_load;

  assign out_load = cmd.resp || cmd.dump_out;

  // sequencer
  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stores and pointers
  cle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (req.op),
    .in_position (req.position),
    .in_value    (req.value),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_item    (rsp.item),
    .out_status  (rsp.status),
    .out_last    (rsp.last)
  );

  // checks
  `CLE_ASSERT(a_no_empty_full, clk, rst, !(sts.empty && sts.full), "list empty and full")
  `CLE_ASSERT(a_out_load_free, clk, rst, !out_load || sts.out_free, "result over held transfer")
  `CLE_ASSERT_NEXT(a_one_at_a_time, clk, rst, req.valid && req.ready, !req.ready, "request taken while busy")

endmodule

`default_nettype wire
